### rtl/tsvd_pkg.sv
`timescale 1ns / 1ps

package tsvd_pkg;

	function automatic int addr_w(input int n);
		return (n > 1) ? $clog2(n) : 1;
	endfunction

	localparam int MAX_SENSORS = 64;
	localparam int MAX_SOURCES = 64;
	localparam int MAX_SAMPLES = 16;
	localparam int MAX_RANK    = 64;

	localparam int SEN_AW = addr_w(MAX_SENSORS);
	localparam int SRC_AW = addr_w(MAX_SOURCES);
	localparam int SMP_AW = addr_w(MAX_SAMPLES);
	localparam int RNK_AW = addr_w(MAX_RANK);
	localparam int SEN_CW = $clog2(MAX_SENSORS + 1);
	localparam int SRC_CW = $clog2(MAX_SOURCES + 1);
	localparam int SMP_CW = $clog2(MAX_SAMPLES + 1);
	localparam int RNK_CW = $clog2(MAX_RANK + 1);

	localparam int U_DEPTH = MAX_SENSORS * MAX_RANK;
	localparam int V_DEPTH = MAX_SOURCES * MAX_RANK;
	localparam int Y_DEPTH = MAX_SENSORS * MAX_SAMPLES;
	localparam int P_DEPTH = MAX_RANK * MAX_SAMPLES;
	localparam int X_DEPTH = MAX_SOURCES * MAX_SAMPLES;
	localparam int U_AW = addr_w(U_DEPTH);
	localparam int V_AW = addr_w(V_DEPTH);
	localparam int Y_AW = addr_w(Y_DEPTH);
	localparam int P_AW = addr_w(P_DEPTH);
	localparam int X_AW = addr_w(X_DEPTH);

	// field and store widths
	localparam int ACT_W   = 3;
	localparam int IDX_W   = 6;
	localparam int DATA_W  = 32;
	localparam int VEC_W   = 16;
	localparam int SV_W    = 32;
	localparam int FF_W    = 32;
	localparam int PROJ_W  = 48;
	localparam int SOL_W   = 32;
	localparam int STAT_W  = 2;
	localparam int FV_W    = 48;
	localparam int CHUNK_W = 17;
	localparam int CHUNK_SH = 16;
	localparam int PROD_W  = FV_W + CHUNK_W;
	localparam int ACC_W   = PROD_W + 2 * CHUNK_SH + RNK_CW;
	localparam int FRAC_SH = 30;

	// configuration register widths and map
	localparam int PADDR_W  = 5;
	localparam int LAMBDA_W = 32;
	localparam int SENS_RW  = 7;
	localparam int SRCS_RW  = 7;
	localparam int SMPS_RW  = 5;
	localparam int RANK_RW  = 7;
	localparam logic [PADDR_W-3:0] REG_LAMBDA  = 3'd0;
	localparam logic [PADDR_W-3:0] REG_SENSORS = 3'd1;
	localparam logic [PADDR_W-3:0] REG_SOURCES = 3'd2;
	localparam logic [PADDR_W-3:0] REG_SAMPLES = 3'd3;
	localparam logic [PADDR_W-3:0] REG_RANK    = 3'd4;

	typedef enum logic [ACT_W-1:0] {
		ACT_LOAD_U   = 3'd0,
		ACT_LOAD_V   = 3'd1,
		ACT_LOAD_S   = 3'd2,
		ACT_LOAD_Y   = 3'd3,
		ACT_COMPUTE  = 3'd4,
		ACT_READ     = 3'd5
	} action_t;

	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
	localparam logic [STAT_W-1:0] STAT_SAT   = 2'd2;
	localparam logic KIND_DONE = 1'b0;
	localparam logic KIND_ELEM = 1'b1;

	// divider
	localparam int DIV_W  = 64;
	localparam int DIV_CW = $clog2(DIV_W + 1);

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] num;
		logic [DIV_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic            done;
		logic [FF_W-1:0] quot;
	} div_rsp_t;

	function automatic logic [VEC_W-1:0] sat16(input logic signed [DATA_W-1:0] v);
		logic [VEC_W-1:0] r;
		if (v > DATA_W'(32767))
			r = 16'h7fff;
		else if (v < -DATA_W'(32768))
			r = 16'h8000;
		else
			r = v[VEC_W-1:0];
		return r;
	endfunction

endpackage

### rtl/tsvd_if.sv
`timescale 1ns / 1ps

interface tsvd_req_if;
	import tsvd_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [ACT_W-1:0]         action;
	logic [IDX_W-1:0]         row_index;
	logic [IDX_W-1:0]         col_index;
	logic signed [DATA_W-1:0] value;
	modport source(output valid, action, row_index, col_index, value, input ready);
	modport sink(input valid, action, row_index, col_index, value, output ready);
endinterface

interface tsvd_rsp_if;
	import tsvd_pkg::*;
	logic                     valid;
	logic                     ready;
	logic                     kind;
	logic [STAT_W-1:0]        status;
	logic signed [SOL_W-1:0]  result_value;
	modport source(output valid, kind, status, result_value, input ready);
	modport sink(input valid, kind, status, result_value, output ready);
endinterface

### rtl/tsvd_ram.sv
`timescale 1ns / 1ps

module tsvd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rd_q <= mem_q[raddr];
	end

	assign rdata = rd_q;
endmodule

### rtl/tsvd_div.sv
`timescale 1ns / 1ps

module tsvd_div (
	input  logic               clk,
	input  logic               arst_n,
	input  tsvd_pkg::div_req_t dreq,
	output tsvd_pkg::div_rsp_t drsp
);
	import tsvd_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [DIV_CW-1:0] cnt_q;
	logic [DIV_W-1:0]  num_q;
	logic [DIV_W-1:0]  den_q;
	logic [DIV_W:0]    rem_q;
	logic [DIV_W-1:0]  quo_q;
	logic [DIV_W:0]    rem_sh;
	logic              fits;

	assign rem_sh = {rem_q[DIV_W-1:0], num_q[DIV_W-1]};
	assign fits   = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (dreq.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CW'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - DIV_CW'(1);
				if (cnt_q == DIV_CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// one quotient bit per cycle, restoring
	always_ff @(posedge clk) begin
		if (dreq.start) begin
			num_q <= dreq.num;
			den_q <= dreq.den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[DIV_W-2:0], 1'b0};
			rem_q <= fits ? (rem_sh - {1'b0, den_q}) : rem_sh;
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	assign drsp.done = done_q;
	assign drsp.quot = (|quo_q[DIV_W-1:FF_W]) ? '1 : quo_q[FF_W-1:0];
endmodule

### rtl/tikhonov_svd_inverse_solver_core.sv
`timescale 1ns / 1ps

// Tikhonov-regularized inverse solver over a preloaded SVD.
// Channels: req carries one item (action, row_index, col_index, value); rsp returns
// one item (kind, status, result_value) for compute and read actions, none for loads.
// Configuration sits on an APB-style port: lambda, sensors, sources, samples, rank.
// Loads write U, V, singular values or measurements in the accepting cycle, so load
// items stream back to back at one per cycle while the core is idle. A read goes
// through ST_READ (one memory read) and then ST_RESP, which loads the output
// register; a read out of range goes straight to ST_RESP.
// A compute item walks the stores: per component r it reads s_r, squares it, forms the
// denominator and runs a restoring divider for the filter factor (a component with a
// zero denominator skips the divider), then streams M*T multiply-accumulates for the
// projection; then the solution pass takes three 16-bit slices of each projected
// value through one multiplier for each source, sample and component. With rank zero
// the solution store is instead cleared to zero for every source and sample.
// Reset clears control state and loads the register defaults; the stores hold nothing
// valid until loaded. No memory clearing pass runs. A stalled receiver holds the
// output register; loads are still taken, while a further compute or read waits in its
// response state until the output register frees up.

module tikhonov_svd_inverse_solver_core (
	input  logic                           clk,
	input  logic                           arst_n,
	tsvd_req_if.sink                       req,
	tsvd_rsp_if.source                     rsp,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [tsvd_pkg::PADDR_W-1:0]   paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready
);
	import tsvd_pkg::*;

	typedef enum logic [12:0] {
		ST_IDLE   = 13'b0000000000001,
		ST_READ   = 13'b0000000000010,
		ST_RESP   = 13'b0000000000100,
		ST_FSTART = 13'b0000000001000,
		ST_FWAIT  = 13'b0000000010000,
		ST_FDEN   = 13'b0000000100000,
		ST_FCHK   = 13'b0000001000000,
		ST_FDIV   = 13'b0000010000000,
		ST_PROJ   = 13'b0000100000000,
		ST_PDRAIN = 13'b0001000000000,
		ST_SOLV   = 13'b0010000000000,
		ST_SDRAIN = 13'b0100000000000,
		ST_SZERO  = 13'b1000000000000
	} state_t;

	state_t state_q;

	// configuration registers
	logic [LAMBDA_W-1:0] lambda_q;
	logic [SENS_RW-1:0]  sensors_q;
	logic [SRCS_RW-1:0]  sources_q;
	logic [SMPS_RW-1:0]  samples_q;
	logic [RANK_RW-1:0]  rank_q;
	logic                cfg_wr;
	logic [PADDR_W-3:0]  cfg_idx;

	// effective sizes
	logic [SEN_CW-1:0] sen_eff, m_n_q;
	logic [SRC_CW-1:0] src_eff, n_n_q;
	logic [SMP_CW-1:0] smp_eff, t_n_q;
	logic [RNK_CW-1:0] rnk_eff, r_n_q;

	// loop counters
	logic [RNK_AW-1:0] r_q;
	logic [SMP_AW-1:0] t_q;
	logic [SEN_AW-1:0] m_q;
	logic [SRC_AW-1:0] n_q;
	logic [1:0]        k_q;
	logic              r_last, t_last, m_last, n_last;

	// input decode
	logic              in_acc;
	action_t           act;
	logic              read_bad;

	// output register and pending result
	logic              out_vld_q;
	logic              out_kind_q;
	logic [STAT_W-1:0] out_stat_q;
	logic [SOL_W-1:0]  out_val_q;
	logic              pend_kind_q;
	logic [STAT_W-1:0] pend_stat_q;
	logic [SOL_W-1:0]  pend_val_q;

	// memory ports
	logic              u_we, v_we, s_we, y_we, f_we, p_we, x_we;
	logic [U_AW-1:0]   u_waddr, u_raddr;
	logic [V_AW-1:0]   v_waddr, v_raddr;
	logic [RNK_AW-1:0] s_waddr;
	logic [Y_AW-1:0]   y_waddr, y_raddr;
	logic [P_AW-1:0]   p_waddr, p_raddr;
	logic [X_AW-1:0]   x_waddr, x_raddr;
	logic [VEC_W-1:0]  ld_vec;
	logic [SV_W-1:0]   ld_sv;
	logic [VEC_W-1:0]  u_rdata, v_rdata, y_rdata;
	logic [SV_W-1:0]   s_rdata;
	logic [FF_W-1:0]   f_rdata, f_wdata;
	logic [PROJ_W-1:0] p_rdata, p_wdata;
	logic [SOL_W:0]    x_rdata, x_wdata;

	// filter factor path
	logic [2*LAMBDA_W-1:0] l2_q;
	logic [2*SV_W-1:0]     s2_q;
	logic [SV_W-1:0]       sv_q;
	logic [DIV_W:0]        den_q;
	logic                  den_zero;
	div_req_t              dreq;
	div_rsp_t              drsp;

	// projection pipeline
	logic                     pa_v_s1, pa_v_s2;
	logic                     pa_first_s1, pa_first_s2, pa_last_s1, pa_last_s2;
	logic [P_AW-1:0]          pa_addr_s1, pa_addr_s2;
	logic signed [2*VEC_W-1:0] pa_prod_s2;
	logic signed [PROJ_W-1:0] pa_acc_q, pa_sum;

	// solution pipeline
	logic                      pb_v_s1, pb_v_s2, pb_v_s3, pb_v_s4;
	logic                      pb_first_s1, pb_first_s2, pb_first_s3;
	logic                      pb_last_s1, pb_last_s2, pb_last_s3;
	logic [1:0]                pb_k_s1, pb_k_s2, pb_k_s3;
	logic [X_AW-1:0]           pb_addr_s1, pb_addr_s2, pb_addr_s3, pb_addr_s4;
	logic signed [CHUNK_W-1:0] chunk, pb_chunk_s2;
	logic signed [FV_W:0]      fv_full;
	logic signed [FV_W-1:0]    pb_fv_s2;
	logic signed [PROD_W-1:0]  pb_prod_s3;
	logic signed [ACC_W-1:0]   pb_term, pb_sum, pb_acc_q, pb_sum_s4;
	logic [ACC_W-1:2*SOL_W-3]  pb_hi;
	logic                      pb_fits;
	logic [SOL_W-1:0]          pb_val;

	// ---------------- configuration port ----------------
	assign pready  = 1'b1;
	assign cfg_idx = paddr[PADDR_W-1:2];
	assign cfg_wr  = psel & penable & pwrite & pready;

	always_comb begin
		unique case (cfg_idx)
			REG_LAMBDA:  prdata = lambda_q;
			REG_SENSORS: prdata = 32'(sensors_q);
			REG_SOURCES: prdata = 32'(sources_q);
			REG_SAMPLES: prdata = 32'(samples_q);
			REG_RANK:    prdata = 32'(rank_q);
			default:     prdata = '0;
		endcase
	end

	// clamp sizes; rank never exceeds sensors, sources or the store depth
	always_comb begin
		int m_i, n_i, t_i, r_i;
		m_i = int'(sensors_q);
		if (m_i < 1) m_i = 1;
		if (m_i > MAX_SENSORS) m_i = MAX_SENSORS;
		n_i = int'(sources_q);
		if (n_i < 1) n_i = 1;
		if (n_i > MAX_SOURCES) n_i = MAX_SOURCES;
		t_i = int'(samples_q);
		if (t_i < 1) t_i = 1;
		if (t_i > MAX_SAMPLES) t_i = MAX_SAMPLES;
		r_i = int'(rank_q);
		if (r_i > m_i) r_i = m_i;
		if (r_i > n_i) r_i = n_i;
		if (r_i > MAX_RANK) r_i = MAX_RANK;
		sen_eff = SEN_CW'(m_i);
		src_eff = SRC_CW'(n_i);
		smp_eff = SMP_CW'(t_i);
		rnk_eff = RNK_CW'(r_i);
	end

	// ---------------- input side ----------------
	assign req.ready = (state_q == ST_IDLE);
	assign in_acc    = req.valid & req.ready;
	assign act       = action_t'(req.action);
	assign read_bad  = (int'(req.row_index) >= int'(src_eff)) ||
	                   (int'(req.col_index) >= int'(smp_eff));

	assign ld_vec = sat16(req.value);
	assign ld_sv  = req.value[DATA_W-1] ? '0 : SV_W'(req.value);

	// loads write straight into the stores; out-of-range indexes are dropped
	assign u_we = in_acc && (act == ACT_LOAD_U) &&
	              (int'(req.row_index) < MAX_SENSORS) && (int'(req.col_index) < MAX_RANK);
	assign v_we = in_acc && (act == ACT_LOAD_V) &&
	              (int'(req.row_index) < MAX_SOURCES) && (int'(req.col_index) < MAX_RANK);
	assign s_we = in_acc && (act == ACT_LOAD_S) && (int'(req.row_index) < MAX_RANK);
	assign y_we = in_acc && (act == ACT_LOAD_Y) &&
	              (int'(req.row_index) < MAX_SENSORS) && (int'(req.col_index) < MAX_SAMPLES);

	assign u_waddr = U_AW'(U_AW'(req.row_index) * U_AW'(MAX_RANK) + U_AW'(req.col_index));
	assign v_waddr = V_AW'(V_AW'(req.row_index) * V_AW'(MAX_RANK) + V_AW'(req.col_index));
	assign s_waddr = RNK_AW'(req.row_index);
	assign y_waddr = Y_AW'(Y_AW'(req.row_index) * Y_AW'(MAX_SAMPLES) + Y_AW'(req.col_index));
	assign x_raddr = X_AW'(X_AW'(req.row_index) * X_AW'(MAX_SAMPLES) + X_AW'(req.col_index));

	// ---------------- loop bounds ----------------
	assign m_last = (SEN_CW'(m_q) + SEN_CW'(1)) == m_n_q;
	assign t_last = (SMP_CW'(t_q) + SMP_CW'(1)) == t_n_q;
	assign n_last = (SRC_CW'(n_q) + SRC_CW'(1)) == n_n_q;
	assign r_last = (RNK_CW'(r_q) + RNK_CW'(1)) == r_n_q;

	// ---------------- engine read addresses ----------------
	assign u_raddr = U_AW'(U_AW'(m_q) * U_AW'(MAX_RANK) + U_AW'(r_q));
	assign y_raddr = Y_AW'(Y_AW'(m_q) * Y_AW'(MAX_SAMPLES) + Y_AW'(t_q));
	assign v_raddr = V_AW'(V_AW'(n_q) * V_AW'(MAX_RANK) + V_AW'(r_q));
	assign p_raddr = P_AW'(P_AW'(r_q) * P_AW'(MAX_SAMPLES) + P_AW'(t_q));

	// ---------------- filter factor ----------------
	assign den_zero   = den_q[DIV_W] | (den_q[DIV_W-1:0] == '0);
	assign dreq.start = (state_q == ST_FCHK) && !den_zero;
	assign dreq.num   = {sv_q, {(DIV_W-SV_W){1'b0}}};
	assign dreq.den   = den_q[DIV_W-1:0];

	tsvd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.dreq   (dreq),
		.drsp   (drsp)
	);

	assign f_we    = ((state_q == ST_FCHK) && den_zero) || ((state_q == ST_FDIV) && drsp.done);
	assign f_wdata = (state_q == ST_FDIV) ? drsp.quot : '0;

	// ---------------- projection accumulate ----------------
	assign pa_sum  = (pa_first_s2 ? '0 : pa_acc_q) + PROJ_W'(pa_prod_s2);
	assign p_we    = pa_v_s2 & pa_last_s2;
	assign p_waddr = pa_addr_s2;
	assign p_wdata = pa_sum;

	// ---------------- solution accumulate ----------------
	// pick the slice of the projected value; the top slice carries the sign
	always_comb begin
		unique case (pb_k_s1)
			2'd0:    chunk = $signed({1'b0, p_rdata[CHUNK_SH-1:0]});
			2'd1:    chunk = $signed({1'b0, p_rdata[2*CHUNK_SH-1:CHUNK_SH]});
			2'd2:    chunk = $signed({p_rdata[PROJ_W-1], p_rdata[PROJ_W-1:2*CHUNK_SH]});
			default: chunk = '0;
		endcase
	end

	assign fv_full = $signed({1'b0, f_rdata}) * $signed(v_rdata);

	always_comb begin
		unique case (pb_k_s3)
			2'd0:    pb_term = ACC_W'(pb_prod_s3);
			2'd1:    pb_term = ACC_W'(pb_prod_s3) <<< CHUNK_SH;
			2'd2:    pb_term = ACC_W'(pb_prod_s3) <<< (2 * CHUNK_SH);
			default: pb_term = '0;
		endcase
	end

	assign pb_sum = (pb_first_s3 ? '0 : pb_acc_q) + pb_term;

	// floor shift to Q16.16, then clip to the signed 32-bit range
	assign pb_hi   = pb_sum_s4[ACC_W-1:2*SOL_W-3];
	assign pb_fits = (&pb_hi) | ~(|pb_hi);
	assign pb_val  = pb_fits ? pb_sum_s4[FRAC_SH+SOL_W-1:FRAC_SH] :
	                 (pb_sum_s4[ACC_W-1] ? {1'b1, {(SOL_W-1){1'b0}}} : {1'b0, {(SOL_W-1){1'b1}}});

	assign x_we    = pb_v_s4 || (state_q == ST_SZERO);
	assign x_waddr = (state_q == ST_SZERO) ?
	                 X_AW'(X_AW'(n_q) * X_AW'(MAX_SAMPLES) + X_AW'(t_q)) : pb_addr_s4;
	assign x_wdata = (state_q == ST_SZERO) ? '0 : {~pb_fits, pb_val};

	// ---------------- stores ----------------
	tsvd_ram #(.WIDTH(VEC_W), .DEPTH(U_DEPTH)) u_mem_u (
		.clk(clk), .we(u_we), .waddr(u_waddr), .wdata(ld_vec),
		.raddr(u_raddr), .rdata(u_rdata));
	tsvd_ram #(.WIDTH(VEC_W), .DEPTH(V_DEPTH)) u_mem_v (
		.clk(clk), .we(v_we), .waddr(v_waddr), .wdata(ld_vec),
		.raddr(v_raddr), .rdata(v_rdata));
	tsvd_ram #(.WIDTH(SV_W), .DEPTH(MAX_RANK)) u_mem_s (
		.clk(clk), .we(s_we), .waddr(s_waddr), .wdata(ld_sv),
		.raddr(r_q), .rdata(s_rdata));
	tsvd_ram #(.WIDTH(VEC_W), .DEPTH(Y_DEPTH)) u_mem_y (
		.clk(clk), .we(y_we), .waddr(y_waddr), .wdata(ld_vec),
		.raddr(y_raddr), .rdata(y_rdata));
	tsvd_ram #(.WIDTH(FF_W), .DEPTH(MAX_RANK)) u_mem_f (
		.clk(clk), .we(f_we), .waddr(r_q), .wdata(f_wdata),
		.raddr(r_q), .rdata(f_rdata));
	tsvd_ram #(.WIDTH(PROJ_W), .DEPTH(P_DEPTH)) u_mem_p (
		.clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
		.raddr(p_raddr), .rdata(p_rdata));
	tsvd_ram #(.WIDTH(SOL_W + 1), .DEPTH(X_DEPTH)) u_mem_x (
		.clk(clk), .we(x_we), .waddr(x_waddr), .wdata(x_wdata),
		.raddr(x_raddr), .rdata(x_rdata));

	// ---------------- control ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			r_q       <= '0;
			t_q       <= '0;
			m_q       <= '0;
			n_q       <= '0;
			k_q       <= '0;
			out_vld_q <= 1'b0;
			pa_v_s1   <= 1'b0;
			pa_v_s2   <= 1'b0;
			pb_v_s1   <= 1'b0;
			pb_v_s2   <= 1'b0;
			pb_v_s3   <= 1'b0;
			pb_v_s4   <= 1'b0;
			lambda_q  <= '0;
			sensors_q <= SENS_RW'(64);
			sources_q <= SRCS_RW'(64);
			samples_q <= SMPS_RW'(16);
			rank_q    <= RANK_RW'(64);
		end else begin
			pa_v_s1 <= (state_q == ST_PROJ);
			pa_v_s2 <= pa_v_s1;
			pb_v_s1 <= (state_q == ST_SOLV);
			pb_v_s2 <= pb_v_s1;
			pb_v_s3 <= pb_v_s2;
			pb_v_s4 <= pb_v_s3 & pb_last_s3;

			// load the output register from the response state, else drop a taken item
			if ((state_q == ST_RESP) && (!out_vld_q || rsp.ready))
				out_vld_q <= 1'b1;
			else if (rsp.ready)
				out_vld_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (act == ACT_COMPUTE) begin
							r_q <= '0;
							t_q <= '0;
							m_q <= '0;
							n_q <= '0;
							k_q <= '0;
							state_q <= (rnk_eff == '0) ? ST_SZERO : ST_FSTART;
						end else if (act == ACT_READ) begin
							state_q <= read_bad ? ST_RESP : ST_READ;
						end
					end
				end
				ST_READ:   state_q <= ST_RESP;
				ST_RESP: begin
					if (!out_vld_q || rsp.ready)
						state_q <= ST_IDLE;
				end
				ST_FSTART: state_q <= ST_FWAIT;
				ST_FWAIT:  state_q <= ST_FDEN;
				ST_FDEN:   state_q <= ST_FCHK;
				ST_FCHK:   state_q <= den_zero ? ST_PROJ : ST_FDIV;
				ST_FDIV: begin
					if (drsp.done)
						state_q <= ST_PROJ;
				end
				ST_PROJ: begin
					if (m_last) begin
						m_q <= '0;
						if (t_last) begin
							t_q     <= '0;
							state_q <= ST_PDRAIN;
						end else begin
							t_q <= t_q + SMP_AW'(1);
						end
					end else begin
						m_q <= m_q + SEN_AW'(1);
					end
				end
				ST_PDRAIN: begin
					// hold until the last projected value is written back
					if (!pa_v_s1 && !pa_v_s2) begin
						if (r_last) begin
							r_q     <= '0;
							state_q <= ST_SOLV;
						end else begin
							r_q     <= r_q + RNK_AW'(1);
							state_q <= ST_FSTART;
						end
					end
				end
				ST_SOLV: begin
					if (k_q == 2'd2) begin
						k_q <= '0;
						if (r_last) begin
							r_q <= '0;
							if (t_last) begin
								t_q <= '0;
								if (n_last) begin
									n_q     <= '0;
									state_q <= ST_SDRAIN;
								end else begin
									n_q <= n_q + SRC_AW'(1);
								end
							end else begin
								t_q <= t_q + SMP_AW'(1);
							end
						end else begin
							r_q <= r_q + RNK_AW'(1);
						end
					end else begin
						k_q <= k_q + 2'd1;
					end
				end
				ST_SDRAIN: begin
					if (!pb_v_s1 && !pb_v_s2 && !pb_v_s3 && !pb_v_s4)
						state_q <= ST_RESP;
				end
				ST_SZERO: begin
					if (t_last) begin
						t_q <= '0;
						if (n_last) begin
							n_q     <= '0;
							state_q <= ST_RESP;
						end else begin
							n_q <= n_q + SRC_AW'(1);
						end
					end else begin
						t_q <= t_q + SMP_AW'(1);
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			if (cfg_wr) begin
				unique case (cfg_idx)
					REG_LAMBDA:  lambda_q  <= pwdata[LAMBDA_W-1:0];
					REG_SENSORS: sensors_q <= pwdata[SENS_RW-1:0];
					REG_SOURCES: sources_q <= pwdata[SRCS_RW-1:0];
					REG_SAMPLES: samples_q <= pwdata[SMPS_RW-1:0];
					REG_RANK:    rank_q    <= pwdata[RANK_RW-1:0];
					default: ;
				endcase
			end
		end
	end

	// ---------------- payload registers ----------------
	always_ff @(posedge clk) begin
		if (in_acc && (act == ACT_COMPUTE)) begin
			m_n_q       <= sen_eff;
			n_n_q       <= src_eff;
			t_n_q       <= smp_eff;
			r_n_q       <= rnk_eff;
			l2_q        <= lambda_q * lambda_q;
			pend_kind_q <= KIND_DONE;
			pend_stat_q <= STAT_OK;
			pend_val_q  <= '0;
		end
		if (in_acc && (act == ACT_READ)) begin
			pend_kind_q <= KIND_ELEM;
			pend_stat_q <= STAT_RANGE;
			pend_val_q  <= '0;
		end
		if (state_q == ST_READ) begin
			pend_stat_q <= x_rdata[SOL_W] ? STAT_SAT : STAT_OK;
			pend_val_q  <= x_rdata[SOL_W-1:0];
		end
		if ((state_q == ST_RESP) && (!out_vld_q || rsp.ready)) begin
			out_kind_q <= pend_kind_q;
			out_stat_q <= pend_stat_q;
			out_val_q  <= pend_val_q;
		end

		if (state_q == ST_FWAIT) begin
			sv_q <= s_rdata;
			s2_q <= s_rdata * s_rdata;
		end
		if (state_q == ST_FDEN)
			den_q <= {1'b0, l2_q} + {1'b0, s2_q};

		// projection pipeline
		pa_first_s1 <= (m_q == '0);
		pa_last_s1  <= m_last;
		pa_addr_s1  <= P_AW'(P_AW'(r_q) * P_AW'(MAX_SAMPLES) + P_AW'(t_q));
		pa_first_s2 <= pa_first_s1;
		pa_last_s2  <= pa_last_s1;
		pa_addr_s2  <= pa_addr_s1;
		pa_prod_s2  <= $signed(u_rdata) * $signed(y_rdata);
		if (pa_v_s2)
			pa_acc_q <= pa_sum;

		// solution pipeline
		pb_first_s1 <= (r_q == '0) && (k_q == 2'd0);
		pb_last_s1  <= r_last && (k_q == 2'd2);
		pb_k_s1     <= k_q;
		pb_addr_s1  <= X_AW'(X_AW'(n_q) * X_AW'(MAX_SAMPLES) + X_AW'(t_q));
		pb_first_s2 <= pb_first_s1;
		pb_last_s2  <= pb_last_s1;
		pb_k_s2     <= pb_k_s1;
		pb_addr_s2  <= pb_addr_s1;
		pb_fv_s2    <= fv_full[FV_W-1:0];
		pb_chunk_s2 <= chunk;
		pb_first_s3 <= pb_first_s2;
		pb_last_s3  <= pb_last_s2;
		pb_k_s3     <= pb_k_s2;
		pb_addr_s3  <= pb_addr_s2;
		pb_prod_s3  <= pb_fv_s2 * pb_chunk_s2;
		if (pb_v_s3)
			pb_acc_q <= pb_sum;
		pb_sum_s4  <= pb_sum;
		pb_addr_s4 <= pb_addr_s3;
	end

	assign rsp.valid        = out_vld_q;
	assign rsp.kind         = out_kind_q;
	assign rsp.status       = out_stat_q;
	assign rsp.result_value = out_val_q;

	// ---------------- checks ----------------
	a_sol_write_phase: assert property (@(posedge clk) disable iff (!arst_n)
		x_we |-> (state_q == ST_SOLV || state_q == ST_SDRAIN || state_q == ST_SZERO))
		else $error("solution store written outside the solution pass");

	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !(pa_v_s1 || pa_v_s2 || pb_v_s1 || pb_v_s2 ||
		                           pb_v_s3 || pb_v_s4))
		else $error("pipeline still busy while taking items");

	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		dreq.start |=> (state_q == ST_FDIV))
		else $error("divider started outside the factor step");

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		drsp.done |-> (state_q == ST_FDIV))
		else $error("divider result arrived with no factor pending");

endmodule
